// ----- design/bs_pkg.sv -----
package bs_pkg;

  // Default capacity of the element buffer.
  localparam int SET_CAPACITY_DEF = 32;

  // Width of one stored element.
  localparam int ELEM_W = 32;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS_RD,
    ST_PASS_HOLD,
    ST_PASS_STEP,
    ST_PASS_TAIL,
    ST_EMIT_RD,
    ST_EMIT_WR
  } bs_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // Store an input beat (or mark overflow).
    logic close;       // The input beat closes the set.
    logic pass_start;  // Read entry zero to open a pass.
    logic hold_first;  // Latch entry zero and read entry one.
    logic step;        // Compare, write the smaller value, keep the larger.
    logic tail;        // Write the carried value at the end of the pass.
    logic emit_rd;     // Read the next sorted entry.
    logic emit;        // Move the read entry into the output register.
  } bs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic single;       // The closing beat makes a set of one element.
    logic pos_at_last;  // The pass has reached its last entry.
    logic last_one;     // The pass just finished was the final one.
    logic pos_at_end;   // The entry being emitted is the last of the set.
    logic out_free;     // The output register can take a new beat.
  } bs_status_t;

endpackage

// ----- design/bs_ctrl.sv -----
module bs_ctrl
  import bs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       set_end,
  input  bs_status_t status,
  output logic       in_stall,
  output bs_cmd_t    cmd
);

  bs_state_t state;
  bs_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && set_end) begin
          state_next = status.single ? ST_EMIT_RD : ST_PASS_RD;
        end
      end
      ST_PASS_RD:   state_next = ST_PASS_HOLD;
      ST_PASS_HOLD: state_next = ST_PASS_STEP;
      ST_PASS_STEP: begin
        if (status.pos_at_last) begin
          state_next = ST_PASS_TAIL;
        end
      end
      ST_PASS_TAIL: state_next = status.last_one ? ST_EMIT_RD : ST_PASS_RD;
      ST_EMIT_RD:   state_next = ST_EMIT_WR;
      ST_EMIT_WR: begin
        if (status.out_free) begin
          state_next = status.pos_at_end ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // Output decode: input is taken only while idle.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.load  = in_valid;
        cmd.close = in_valid && set_end;
      end
      ST_PASS_RD:   cmd.pass_start = 1'b1;
      ST_PASS_HOLD: cmd.hold_first = 1'b1;
      ST_PASS_STEP: cmd.step       = 1'b1;
      ST_PASS_TAIL: cmd.tail       = 1'b1;
      ST_EMIT_RD:   cmd.emit_rd    = 1'b1;
      ST_EMIT_WR:   cmd.emit       = status.out_free;
      default:      in_stall       = 1'b1;
    endcase
  end

endmodule

// ----- design/bs_datapath.sv -----
module bs_datapath
  import bs_pkg::*;
#(
  parameter int SET_CAPACITY = SET_CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  bs_cmd_t                  cmd,
  output bs_status_t               status,
  input  logic signed [ELEM_W-1:0] sample_value,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic signed [ELEM_W-1:0] sorted_value,
  output logic                     run_end,
  output logic                     dropped_flag
);

  localparam int IDX_W = $clog2(SET_CAPACITY);
  localparam int CNT_W = $clog2(SET_CAPACITY + 1);

  logic [ELEM_W-1:0] mem [SET_CAPACITY];
  logic [ELEM_W-1:0] rd_data;
  logic [ELEM_W-1:0] held;
  logic [CNT_W-1:0]  fill;
  logic              overflow;
  logic [IDX_W-1:0]  pos;
  logic [IDX_W-1:0]  last;

  logic              full;
  logic [IDX_W-1:0]  fill_idx;
  logic [IDX_W-1:0]  end_idx;
  logic              greater;
  logic [ELEM_W-1:0] low_value;
  logic [ELEM_W-1:0] high_value;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [ELEM_W-1:0] wr_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;

  assign full     = (fill == CNT_W'(SET_CAPACITY));
  assign fill_idx = fill[IDX_W-1:0];
  assign end_idx  = IDX_W'(fill - CNT_W'(1));

  // Signed compare of the carried value against the entry just read.
  assign greater    = $signed(held) > $signed(rd_data);
  assign low_value  = greater ? rd_data : held;
  assign high_value = greater ? held : rd_data;

  // Status toward the controller.
  assign status.single      = (fill == '0);
  assign status.pos_at_last = (pos == last);
  assign status.last_one    = (last == IDX_W'(1));
  assign status.pos_at_end  = (pos == end_idx);
  assign status.out_free    = !out_valid || !out_stall;

  // Write port select.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill_idx;
    wr_data = sample_value;
    priority if (cmd.load) begin
      wr_en = !full;
    end else if (cmd.step) begin
      wr_en   = 1'b1;
      wr_addr = pos - IDX_W'(1);
      wr_data = low_value;
    end else if (cmd.tail) begin
      wr_en   = 1'b1;
      wr_addr = last;
      wr_data = held;
    end else begin
      wr_en = 1'b0;
    end
  end

  // Read port select.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pos;
    priority if (cmd.pass_start) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (cmd.hold_first || cmd.emit_rd) begin
      rd_en = 1'b1;
    end else if (cmd.step && !status.pos_at_last) begin
      rd_en   = 1'b1;
      rd_addr = pos + IDX_W'(1);
    end else begin
      rd_en = 1'b0;
    end
  end

  // Element buffer with a registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Fill count and overflow mark for the current set.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      overflow <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        overflow <= 1'b1;
      end else begin
        fill <= fill + CNT_W'(1);
      end
    end else if (cmd.emit && status.pos_at_end) begin
      fill     <= '0;
      overflow <= 1'b0;
    end
  end

  // Position and pass-end pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      last <= '0;
    end else begin
      if (cmd.close) begin
        pos  <= '0;
        last <= full ? IDX_W'(SET_CAPACITY - 1) : fill_idx;
      end
      if (cmd.pass_start) begin
        pos <= IDX_W'(1);
      end
      if ((cmd.step && !status.pos_at_last) || cmd.emit) begin
        pos <= pos + IDX_W'(1);
      end
      if (cmd.tail) begin
        pos  <= '0;
        last <= last - IDX_W'(1);
      end
    end
  end

  // The larger value is carried along the pass.
  always_ff @(posedge clk) begin
    if (cmd.hold_first) begin
      held <= rd_data;
    end else if (cmd.step) begin
      held <= high_value;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sorted_value <= rd_data;
      run_end      <= status.pos_at_end;
      dropped_flag <= overflow;
    end
  end

endmodule

// ----- design/bubble_sort.sv -----
// Input beats are taken only while idle; the closing beat ends the load.
// A set of n values is then sorted in passes whose end entry falls from n-1 to 1;
// each reads entry zero, compare-exchanges along and writes the carried value last.
// Values are then read one at a time and moved to the output register when free.
// Reset clears the controller, the fill count, the overflow mark and out_valid;
// buffer contents are not cleared and need no clearing pass.
module bubble_sort
  import bs_pkg::*;
#(
  parameter int SET_CAPACITY = SET_CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [ELEM_W-1:0] sample_value,
  input  logic                     set_end,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ELEM_W-1:0] sorted_value,
  output logic                     run_end,
  output logic                     dropped_flag
);

  bs_cmd_t    cmd;
  bs_status_t status;

  // Sequencer for load, sort passes and emit.
  bs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .set_end  (set_end),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // Buffer, compare-exchange unit and output register.
  bs_datapath #(
    .SET_CAPACITY (SET_CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample_value (sample_value),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .sorted_value (sorted_value),
    .run_end      (run_end),
    .dropped_flag (dropped_flag)
  );

  // A new beat is never moved into an occupied, stalled output register.
  assert property (@(posedge clk) disable iff (rst) cmd.emit |-> status.out_free)
    else $error("emit into a stalled output register");

  // Datapath commands other than close never overlap.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.pass_start, cmd.hold_first, cmd.step, cmd.tail,
              cmd.emit_rd, cmd.emit}))
    else $error("overlapping datapath commands");

  // Closing a set only happens on an accepted beat.
  assert property (@(posedge clk) disable iff (rst)
    cmd.close |-> (cmd.load && in_valid && !in_stall))
    else $error("set closed without an accepted beat");

  // The block is ready for input right after reset.
  assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled after reset");

endmodule
